FILE: rtl/core/bxlr_pkg.sv
// Package for the explicit bidi level resolver.
// Holds the class codes, override codes, stack entry and result types.
// Used by every module of the block but bxlr_ram; depends on nothing.
package bxlr_pkg;

    localparam int MAX_LEVEL_DEF  = 125;
    localparam int COUNT_BITS_DEF = 16;

    localparam int LEVEL_W = 7;
    localparam int CLASS_W = 5;
    localparam int ENTRY_W = 10;

    localparam logic [LEVEL_W-1:0] VI_MAX = 7'd127;

    localparam logic [CLASS_W-1:0] C_L   = 5'd0;
    localparam logic [CLASS_W-1:0] C_R   = 5'd1;
    localparam logic [CLASS_W-1:0] C_BN  = 5'd9;
    localparam logic [CLASS_W-1:0] C_B   = 5'd10;
    localparam logic [CLASS_W-1:0] C_LRE = 5'd14;
    localparam logic [CLASS_W-1:0] C_LRO = 5'd15;
    localparam logic [CLASS_W-1:0] C_RLE = 5'd16;
    localparam logic [CLASS_W-1:0] C_RLO = 5'd17;
    localparam logic [CLASS_W-1:0] C_PDF = 5'd18;
    localparam logic [CLASS_W-1:0] C_LRI = 5'd19;
    localparam logic [CLASS_W-1:0] C_RLI = 5'd20;
    localparam logic [CLASS_W-1:0] C_FSI = 5'd21;
    localparam logic [CLASS_W-1:0] C_PDI = 5'd22;

    localparam logic [1:0] OV_NONE = 2'd0;
    localparam logic [1:0] OV_L    = 2'd1;
    localparam logic [1:0] OV_R    = 2'd2;

    typedef struct packed {
        logic               iso;
        logic [1:0]         ov;
        logic [LEVEL_W-1:0] lvl;
    } t_entry;

    typedef struct packed {
        logic [LEVEL_W-1:0] level;
        logic [CLASS_W-1:0] direction;
        logic               removed;
    } t_result;

endpackage

FILE: rtl/core/bxlr_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// Parameters set the word width and the depth; no package dependency.
module bxlr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: rtl/core/bxlr_ctrl.sv
// Sequencer of the explicit level resolver: cached stack top, counters,
// and read-modify-write of the directional status stack in the RAM.
// Depends on bxlr_pkg.
module bxlr_ctrl
    import bxlr_pkg::*;
#(
    parameter int MAX_LEVEL   = MAX_LEVEL_DEF,
    parameter int COUNT_BITS  = COUNT_BITS_DEF,
    localparam int STACK_DEPTH = MAX_LEVEL + 2,
    localparam int AW          = $clog2(STACK_DEPTH),
    localparam int CW          = $clog2(STACK_DEPTH + 1)
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_para_level,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic [CLASS_W-1:0] i_char_class,
    input  logic               i_fsi_rtl,
    input  logic               i_end_of_paragraph,
    input  logic               i_out_free,
    output logic               o_res_valid,
    output t_result            o_res,
    output logic               o_ram_we,
    output logic [AW-1:0]      o_ram_waddr,
    output t_entry             o_ram_wdata,
    output logic [AW-1:0]      o_ram_raddr,
    input  t_entry             i_ram_rdata
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_LOAD,
        S_POP,
        S_POPLD,
        S_PDIRES,
        S_EMIT
    } t_state;

    localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};
    localparam logic [COUNT_BITS-1:0] OVF_ONE   = COUNT_BITS'(1);
    localparam logic [LEVEL_W-1:0]    VI_ONE    = LEVEL_W'(1);
    localparam logic [CW-1:0]         CNT_ONE   = CW'(1);
    localparam logic [CW-1:0]         CNT_TWO   = CW'(2);
    localparam logic [CW-1:0]         CNT_FULL  = CW'(STACK_DEPTH);

    t_state                r_state, n_state;
    logic [CLASS_W-1:0]    r_cls, n_cls;
    logic                  r_fsi, n_fsi;
    logic                  r_eop, n_eop;
    logic [CW-1:0]         r_count, n_count;
    t_entry                r_top, n_top;
    logic [COUNT_BITS-1:0] r_ovi, n_ovi;
    logic [COUNT_BITS-1:0] r_ove, n_ove;
    logic [LEVEL_W-1:0]    r_vi, n_vi;
    logic                  r_last, n_last;
    t_result               r_res, n_res;

    logic                  accept;
    logic [LEVEL_W-1:0]    cur;
    logic [LEVEL_W:0]      cur_x, nodd, neven, tgt;
    logic [CLASS_W-1:0]    ovr_dir;
    logic                  is_emb, is_iso, go_rtl, push_ok;
    logic [1:0]            push_ov;
    t_entry                push_entry;
    logic [CW-1:0]         cnt_m2;

    assign o_ready     = (r_state == S_IDLE) || (r_state == S_EMIT && i_out_free);
    assign accept      = i_valid && o_ready;
    assign o_res_valid = (r_state == S_EMIT);
    assign o_res       = r_res;

    assign cur   = (r_count == CNT_ONE) ? {{(LEVEL_W-1){1'b0}}, i_para_level} : r_top.lvl;
    assign cur_x = {1'b0, cur};
    assign nodd  = cur[0] ? cur_x + 8'd2 : cur_x + 8'd1;
    assign neven = cur[0] ? cur_x + 8'd1 : cur_x + 8'd2;

    always_comb begin
        if (r_top.ov == OV_L) begin
            ovr_dir = C_L;
        end else if (r_top.ov == OV_R) begin
            ovr_dir = C_R;
        end else begin
            ovr_dir = r_cls;
        end
    end

    assign is_emb  = (r_cls == C_LRE) || (r_cls == C_LRO) || (r_cls == C_RLE) || (r_cls == C_RLO);
    assign is_iso  = (r_cls == C_LRI) || (r_cls == C_RLI) || (r_cls == C_FSI);
    assign go_rtl  = is_emb ? (r_cls == C_RLE || r_cls == C_RLO)
                            : (r_cls == C_RLI || (r_cls == C_FSI && r_fsi));
    assign tgt     = go_rtl ? nodd : neven;
    assign push_ok = (tgt <= (LEVEL_W+1)'(MAX_LEVEL)) && (r_ovi == '0) && (r_ove == '0)
                     && (r_count < CNT_FULL);
    assign push_ov = (r_cls == C_RLO) ? OV_R : ((r_cls == C_LRO) ? OV_L : OV_NONE);

    assign push_entry.iso = is_iso;
    assign push_entry.ov  = is_iso ? OV_NONE : push_ov;
    assign push_entry.lvl = tgt[LEVEL_W-1:0];

    assign cnt_m2      = r_count - CNT_TWO;
    assign o_ram_waddr = r_count[AW-1:0];
    assign o_ram_wdata = push_entry;
    assign o_ram_raddr = cnt_m2[AW-1:0];

    always_comb begin
        n_state  = r_state;
        n_cls    = r_cls;
        n_fsi    = r_fsi;
        n_eop    = r_eop;
        n_count  = r_count;
        n_top    = r_top;
        n_ovi    = r_ovi;
        n_ove    = r_ove;
        n_vi     = r_vi;
        n_last   = r_last;
        n_res    = r_res;
        o_ram_we = 1'b0;

        unique case (r_state)
            S_IDLE: begin
            end
            S_EXEC: begin
                n_res.level     = cur;
                n_res.direction = r_cls;
                n_res.removed   = 1'b0;
                n_state         = S_EMIT;
                unique case (r_cls)
                    C_LRE, C_LRO, C_RLE, C_RLO: begin
                        n_res.removed = 1'b1;
                        if (push_ok) begin
                            o_ram_we = 1'b1;
                            n_top    = push_entry;
                            n_count  = r_count + CNT_ONE;
                        end else if (r_ovi == '0 && r_ove != COUNT_MAX) begin
                            n_ove = r_ove + OVF_ONE;
                        end
                    end
                    C_LRI, C_RLI, C_FSI: begin
                        n_res.direction = ovr_dir;
                        if (push_ok) begin
                            o_ram_we = 1'b1;
                            n_top    = push_entry;
                            n_count  = r_count + CNT_ONE;
                            if (r_vi < VI_MAX) begin
                                n_vi = r_vi + VI_ONE;
                            end
                        end else if (r_ovi != COUNT_MAX) begin
                            n_ovi = r_ovi + OVF_ONE;
                        end
                    end
                    C_PDI: begin
                        n_res.direction = ovr_dir;
                        if (r_ovi != '0) begin
                            n_ovi = r_ovi - OVF_ONE;
                        end else if (r_vi != '0) begin
                            n_ove   = '0;
                            n_vi    = r_vi - VI_ONE;
                            n_state = S_POP;
                        end
                    end
                    C_PDF: begin
                        n_res.removed = 1'b1;
                        if (r_ovi != '0) begin
                            n_ovi = r_ovi;
                        end else if (r_ove != '0) begin
                            n_ove = r_ove - OVF_ONE;
                        end else if (r_count >= CNT_TWO && !r_top.iso) begin
                            n_count = r_count - CNT_ONE;
                            if (r_count == CNT_TWO) begin
                                n_top = '0;
                            end else begin
                                n_state = S_LOAD;
                            end
                        end
                    end
                    C_B: begin
                        n_res.level = {{(LEVEL_W-1){1'b0}}, i_para_level};
                    end
                    C_BN: begin
                        n_res.removed = 1'b1;
                    end
                    default: begin
                        n_res.direction = ovr_dir;
                    end
                endcase
                if ((r_eop || r_cls == C_B) && n_state != S_POP) begin
                    n_count = CNT_ONE;
                    n_top   = '0;
                    n_ovi   = '0;
                    n_ove   = '0;
                    n_vi    = '0;
                    n_state = S_EMIT;
                end
            end
            S_LOAD: begin
                n_top   = i_ram_rdata;
                n_state = S_EMIT;
            end
            S_POP: begin
                if (r_count == CNT_ONE) begin
                    n_state = S_PDIRES;
                end else begin
                    n_count = r_count - CNT_ONE;
                    n_last  = r_top.iso;
                    n_state = S_POPLD;
                end
            end
            S_POPLD: begin
                n_top   = (r_count == CNT_ONE) ? '0 : i_ram_rdata;
                n_state = r_last ? S_PDIRES : S_POP;
            end
            S_PDIRES: begin
                n_res.level     = cur;
                n_res.direction = ovr_dir;
                n_res.removed   = 1'b0;
                n_state         = S_EMIT;
                if (r_eop) begin
                    n_count = CNT_ONE;
                    n_top   = '0;
                    n_ovi   = '0;
                    n_ove   = '0;
                    n_vi    = '0;
                end
            end
            S_EMIT: begin
                if (i_out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        if (accept) begin
            n_cls   = i_char_class;
            n_fsi   = i_fsi_rtl;
            n_eop   = i_end_of_paragraph;
            n_state = S_EXEC;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cls  <= n_cls;
        r_fsi  <= n_fsi;
        r_eop  <= n_eop;
        r_last <= n_last;
        r_res  <= n_res;
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= CNT_ONE;
            r_top   <= '0;
            r_ovi   <= '0;
            r_ove   <= '0;
            r_vi    <= '0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_top   <= n_top;
            r_ovi   <= n_ovi;
            r_ove   <= n_ove;
            r_vi    <= n_vi;
        end
    end

endmodule

FILE: rtl/core/bidi_explicit_level_resolver.sv
// Top level of the explicit bidi embedding level resolver.
// Holds the paragraph level register, the output register and the stack RAM.
// Depends on bxlr_pkg, bxlr_ram and bxlr_ctrl.
//
// The input channel (i_valid, o_ready) takes one item per character: its bidi
// class, the resolved direction of an FSI and an end-of-paragraph flag. The
// output channel (o_valid, i_ready) returns one item per input item, in order:
// the embedding level, the direction after any override, and the removal flag.
// The paragraph level is written through i_cfg_we and i_cfg_wdata, by the user only while idle (not enforced).
//
// Most items pass through an execute and an emit state, and the next item is
// accepted in the cycle in which a result is loaded into the output register.
// A PDF that pops the stack to a pushed entry also passes a load state, since the
// new stack top is read back from the RAM. A PDI that closes an isolate passes a
// pop and a load state for each entry it pops, each pop a registered RAM read,
// then a result state. The output register holds a result while the receiver
// stalls; the block still finishes the next item behind it before it waits.
// Reset clears the stack to its single paragraph entry, clears the counters,
// sets the paragraph level to left-to-right and empties the output register.
module bidi_explicit_level_resolver
    import bxlr_pkg::*;
#(
    parameter int MAX_LEVEL  = MAX_LEVEL_DEF,
    parameter int COUNT_BITS = COUNT_BITS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic               i_cfg_wdata,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic [CLASS_W-1:0] i_char_class,
    input  logic               i_fsi_rtl,
    input  logic               i_end_of_paragraph,
    output logic               o_valid,
    input  logic               i_ready,
    output logic [LEVEL_W-1:0] o_level,
    output logic [CLASS_W-1:0] o_direction,
    output logic               o_removed
);

    localparam int STACK_DEPTH = MAX_LEVEL + 2;
    localparam int AW          = $clog2(STACK_DEPTH);

    logic          r_para_level;
    logic          r_out_valid;
    t_result       r_out;
    logic          out_free;
    logic          res_valid;
    t_result       res;
    logic          ram_we;
    logic [AW-1:0] ram_waddr, ram_raddr;
    t_entry        ram_wdata, ram_rdata;

    assign out_free = !r_out_valid || i_ready;

    bxlr_ctrl #(
        .MAX_LEVEL  (MAX_LEVEL),
        .COUNT_BITS (COUNT_BITS)
    ) u_ctrl (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_para_level       (r_para_level),
        .i_valid            (i_valid),
        .o_ready            (o_ready),
        .i_char_class       (i_char_class),
        .i_fsi_rtl          (i_fsi_rtl),
        .i_end_of_paragraph (i_end_of_paragraph),
        .i_out_free         (out_free),
        .o_res_valid        (res_valid),
        .o_res              (res),
        .o_ram_we           (ram_we),
        .o_ram_waddr        (ram_waddr),
        .o_ram_wdata        (ram_wdata),
        .o_ram_raddr        (ram_raddr),
        .i_ram_rdata        (ram_rdata)
    );

    bxlr_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (STACK_DEPTH)
    ) u_stack_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (res_valid && out_free) begin
            r_out <= res;
        end
        if (!i_rst_n) begin
            r_para_level <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_para_level <= i_cfg_wdata;
            end
            if (res_valid && out_free) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_valid     = r_out_valid;
    assign o_level     = r_out.level;
    assign o_direction = r_out.direction;
    assign o_removed   = r_out.removed;

endmodule

FILE: rtl/core/bxlr_chk.sv
// Port-level checker for the explicit bidi level resolver, bound to the top.
// Depends on bxlr_pkg.
module bxlr_chk
    import bxlr_pkg::*;
(
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_valid,
    input logic               o_ready,
    input logic               o_valid,
    input logic               i_ready,
    input logic [LEVEL_W-1:0] o_level,
    input logic [CLASS_W-1:0] o_direction,
    input logic               o_removed
);

    logic [1:0] r_pend;
    logic       acc_in, acc_out;

    assign acc_in  = i_valid && o_ready;
    assign acc_out = o_valid && i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend <= 2'd0;
        end else if (acc_in && !acc_out) begin
            r_pend <= r_pend + 2'd1;
        end else if (acc_out && !acc_in) begin
            r_pend <= r_pend - 2'd1;
        end
    end

    a_reset_empty: assert property (@(posedge i_clk) !i_rst_n |=> !o_valid)
        else $error("output valid after reset");

    a_no_invented: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> r_pend != 2'd0)
        else $error("result shown without an accepted item");

    a_pend_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pend != 2'd3)
        else $error("more than two items in flight");

    a_removed_class: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_removed |-> o_direction == C_LRE || o_direction == C_LRO
            || o_direction == C_RLE || o_direction == C_RLO
            || o_direction == C_PDF || o_direction == C_BN)
        else $error("removed item with a class that is not removable");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_level) && $stable(o_direction)
            && $stable(o_removed))
        else $error("stalled result changed");

endmodule

bind bidi_explicit_level_resolver bxlr_chk u_bxlr_chk (.*);

FILE: verif/tb_bidi_explicit_level_resolver.sv
`timescale 1ns / 1ps
// Self-checking testbench for bidi_explicit_level_resolver.
// Holds its own explicit-level predictor, a queued item driver and a result checker.
// Depends on bxlr_pkg and the RTL of the block.
module tb_bidi_explicit_level_resolver;
    import bxlr_pkg::*;

    localparam int MAX_LEVEL    = MAX_LEVEL_DEF;
    localparam int COUNT_BITS   = COUNT_BITS_DEF;
    localparam int STACK_DEPTH  = MAX_LEVEL + 2;
    localparam int unsigned COUNT_TOP = (1 << COUNT_BITS) - 1;
    localparam int RANDOM_ITEMS = 1650;
    localparam int HOLD_AT      = 200;
    localparam int HOLD_CYCLES  = 60;
    localparam int DRAIN_CYCLES = 2 * STACK_DEPTH + 8;
    localparam int IDLE_PCT     = 7;
    localparam int SAT_OPENERS  = 390;
    localparam int SAT_CLOSERS  = 265;

    localparam logic [CLASS_W-1:0] C_AL  = 5'd2;
    localparam logic [CLASS_W-1:0] C_EN  = 5'd3;
    localparam logic [CLASS_W-1:0] C_ES  = 5'd4;
    localparam logic [CLASS_W-1:0] C_ET  = 5'd5;
    localparam logic [CLASS_W-1:0] C_AN  = 5'd6;
    localparam logic [CLASS_W-1:0] C_CS  = 5'd7;
    localparam logic [CLASS_W-1:0] C_NSM = 5'd8;
    localparam logic [CLASS_W-1:0] C_S   = 5'd11;
    localparam logic [CLASS_W-1:0] C_WS  = 5'd12;
    localparam logic [CLASS_W-1:0] C_ON  = 5'd13;
    localparam logic [CLASS_W-1:0] C_TOP_CODE = 5'd31;

    localparam int OPEN_EMB_FIRST = 0;
    localparam int OPEN_EMB_LAST  = 3;
    localparam int OPEN_ISO_FIRST = 4;
    localparam int OPEN_ISO_LAST  = 6;

    typedef struct packed {
        logic [CLASS_W-1:0] cls;
        logic               fsi_rtl;
        logic               eop;
    } t_char;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_cfg_we = 1'b0;
    logic               i_cfg_wdata = 1'b0;
    logic               i_valid = 1'b0;
    logic [CLASS_W-1:0] i_char_class = '0;
    logic               i_fsi_rtl = 1'b0;
    logic               i_end_of_paragraph = 1'b0;
    logic               i_ready = 1'b0;
    logic               o_ready;
    logic               o_valid;
    logic [LEVEL_W-1:0] o_level;
    logic [CLASS_W-1:0] o_direction;
    logic               o_removed;

    t_char   char_queue[$];
    t_result expected_levels[$];
    int      mismatches = 0;
    int      results_seen = 0;
    int      hold_left = 0;
    bit      hold_done = 1'b0;
    logic    calm = 1'b0;
    int      queued_count = 0;

    t_entry      dss[STACK_DEPTH];
    int unsigned dss_count = 1;
    int unsigned ovf_iso = 0;
    int unsigned ovf_emb = 0;
    int unsigned valid_iso = 0;
    logic        para_lvl = 1'b0;

    bidi_explicit_level_resolver #(
        .MAX_LEVEL (MAX_LEVEL),
        .COUNT_BITS(COUNT_BITS)
    ) i_dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_wdata       (i_cfg_wdata),
        .i_valid           (i_valid),
        .o_ready           (o_ready),
        .i_char_class      (i_char_class),
        .i_fsi_rtl         (i_fsi_rtl),
        .i_end_of_paragraph(i_end_of_paragraph),
        .o_valid           (o_valid),
        .i_ready           (i_ready),
        .o_level           (o_level),
        .o_direction       (o_direction),
        .o_removed         (o_removed)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #10ms;
        $display("simulation failed");
        $finish;
    end

    function automatic void clear_paragraph();
        dss[0] = '0;
        dss_count = 1;
        ovf_iso = 0;
        ovf_emb = 0;
        valid_iso = 0;
    endfunction

    function automatic int unsigned cur_level();
        t_entry e;
        e = dss[dss_count - 1];
        if (dss_count <= 1) begin
            return 32'(para_lvl);
        end
        return 32'(e.lvl);
    endfunction

    function automatic bit is_isolate(int unsigned idx);
        t_entry e;
        e = dss[idx];
        return e.iso;
    endfunction

    function automatic logic [CLASS_W-1:0] steer(logic [CLASS_W-1:0] cls);
        t_entry e;
        e = dss[dss_count - 1];
        if (e.ov == OV_L) begin
            return C_L;
        end
        if (e.ov == OV_R) begin
            return C_R;
        end
        return cls;
    endfunction

    function automatic bit room_for(int unsigned target);
        return target <= MAX_LEVEL && ovf_iso == 0 && ovf_emb == 0 && dss_count < STACK_DEPTH;
    endfunction

    function automatic void push_entry(int unsigned target, logic [1:0] ov, logic iso);
        t_entry e;
        e.iso = iso;
        e.ov = ov;
        e.lvl = target[LEVEL_W-1:0];
        dss[dss_count] = e;
        dss_count++;
    endfunction

    function automatic t_result resolve_explicit(logic [CLASS_W-1:0] cls, logic fsi, logic eop);
        int unsigned cur;
        int unsigned nodd;
        int unsigned neven;
        int unsigned target;
        logic [1:0]  ov;
        logic        ends;
        t_result     r;
        cur = cur_level();
        nodd = cur[0] ? cur + 2 : cur + 1;
        neven = cur[0] ? cur + 1 : cur + 2;
        r.level = cur[LEVEL_W-1:0];
        r.direction = cls;
        r.removed = 1'b0;
        ends = eop;
        case (cls)
            C_RLE, C_LRE, C_RLO, C_LRO: begin
                target = (cls == C_RLE || cls == C_RLO) ? nodd : neven;
                ov = (cls == C_RLO) ? OV_R : ((cls == C_LRO) ? OV_L : OV_NONE);
                r.removed = 1'b1;
                if (room_for(target)) begin
                    push_entry(target, ov, 1'b0);
                end else if (ovf_iso == 0 && ovf_emb < COUNT_TOP) begin
                    ovf_emb++;
                end
            end
            C_RLI, C_LRI, C_FSI: begin
                target = (cls == C_RLI || (cls == C_FSI && fsi)) ? nodd : neven;
                r.direction = steer(cls);
                if (room_for(target)) begin
                    if (valid_iso < VI_MAX) begin
                        valid_iso++;
                    end
                    push_entry(target, OV_NONE, 1'b1);
                end else if (ovf_iso < COUNT_TOP) begin
                    ovf_iso++;
                end
            end
            C_PDI: begin
                if (ovf_iso > 0) begin
                    ovf_iso--;
                end else if (valid_iso != 0) begin
                    ovf_emb = 0;
                    while (dss_count > 1 && !is_isolate(dss_count - 1)) begin
                        dss_count--;
                    end
                    if (dss_count > 1) begin
                        dss_count--;
                    end
                    valid_iso--;
                end
                cur = cur_level();
                r.level = cur[LEVEL_W-1:0];
                r.direction = steer(cls);
            end
            C_PDF: begin
                r.removed = 1'b1;
                if (ovf_iso > 0) begin
                end else if (ovf_emb > 0) begin
                    ovf_emb--;
                end else if (dss_count >= 2 && !is_isolate(dss_count - 1)) begin
                    dss_count--;
                end
            end
            C_B: begin
                r.level = LEVEL_W'(para_lvl);
                ends = 1'b1;
            end
            C_BN: begin
                r.removed = 1'b1;
            end
            default: begin
                r.direction = steer(cls);
            end
        endcase
        if (ends) begin
            clear_paragraph();
        end
        return r;
    endfunction

    always @(posedge i_clk) begin : drive
        t_char next;
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            if (i_valid && o_ready) begin
                expected_levels.insert(expected_levels.size(),
                    resolve_explicit(i_char_class, i_fsi_rtl, i_end_of_paragraph));
            end
            if (!i_valid || o_ready) begin
                if (char_queue.size() != 0 && (calm || $urandom_range(0, 99) >= IDLE_PCT)) begin
                    next = char_queue.pop_front();
                    i_char_class <= next.cls;
                    i_fsi_rtl <= next.fsi_rtl;
                    i_end_of_paragraph <= next.eop;
                    i_valid <= 1'b1;
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    task automatic flag_field(string what, int unsigned want, int unsigned got);
        mismatches++;
        $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
    endtask

    always @(posedge i_clk) begin : hold_off
        if (!i_rst_n) begin
            hold_left <= 0;
        end else if (!hold_done && results_seen >= HOLD_AT) begin
            hold_left <= HOLD_CYCLES;
            hold_done <= 1'b1;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end
    end

    always @(posedge i_clk) begin : watch
        t_result want;
        if (!i_rst_n) begin
            i_ready <= 1'b0;
        end else begin
            if (o_valid && i_ready) begin
                if (expected_levels.size() == 0) begin
                    mismatches++;
                    $display("%0t ns: unexpected item, expected none, actual %0d/%0d/%0d",
                             $time, o_level, o_direction, o_removed);
                end else begin
                    want = expected_levels.pop_front();
                    if (o_level !== want.level) begin
                        flag_field("level", 32'(want.level), 32'(o_level));
                    end
                    if (o_direction !== want.direction) begin
                        flag_field("direction", 32'(want.direction), 32'(o_direction));
                    end
                    if (o_removed !== want.removed) begin
                        flag_field("removed", 32'(want.removed), 32'(o_removed));
                    end
                end
                results_seen++;
            end
            if (hold_left != 0) begin
                i_ready <= 1'b0;
            end else begin
                i_ready <= calm || ($urandom_range(0, 99) >= IDLE_PCT);
            end
        end
    end

    task automatic put(logic [CLASS_W-1:0] cls, logic fsi, logic eop);
        t_char c;
        c.cls = cls;
        c.fsi_rtl = fsi;
        c.eop = eop;
        char_queue.insert(char_queue.size(), c);
        queued_count++;
    endtask

    function automatic logic coin();
        return 1'($urandom_range(0, 1));
    endfunction

    function automatic logic [CLASS_W-1:0] plain_class();
        logic [CLASS_W-1:0] c;
        c = CLASS_W'($urandom_range(C_L, C_ON));
        if (c == C_B) begin
            c = C_WS;
        end
        return c;
    endfunction

    function automatic logic [CLASS_W-1:0] opener(int first, int last);
        case ($urandom_range(first, last))
            0: return C_LRE;
            1: return C_LRO;
            2: return C_RLE;
            3: return C_RLO;
            4: return C_LRI;
            5: return C_RLI;
            default: return C_FSI;
        endcase
    endfunction

    task automatic mixed_body(int len);
        int k;
        int pick;
        for (k = 0; k < len; k++) begin
            pick = $urandom_range(0, 99);
            if (pick < 38) begin
                put(plain_class(), coin(), 1'b0);
            end else if (pick < 60) begin
                put(opener(OPEN_EMB_FIRST, OPEN_ISO_LAST), coin(), 1'b0);
            end else if (pick < 72) begin
                put(C_PDF, coin(), 1'b0);
            end else if (pick < 86) begin
                put(C_PDI, coin(), 1'b0);
            end else if (pick < 92) begin
                put(C_BN, coin(), 1'b0);
            end else if (pick < 97) begin
                put(CLASS_W'($urandom_range(C_PDI + 1, C_TOP_CODE)), coin(), 1'b0);
            end else begin
                put(CLASS_W'($urandom_range(C_L, C_TOP_CODE)), coin(), coin());
            end
        end
    endtask

    task automatic close_paragraph();
        int pick;
        pick = $urandom_range(0, 9);
        if (pick < 5) begin
            put(C_B, coin(), coin());
        end else if (pick < 8) begin
            put(plain_class(), coin(), 1'b1);
        end
    endtask

    task automatic mixed_paragraph();
        mixed_body($urandom_range(3, 40));
        close_paragraph();
    endtask

    task automatic deep_paragraph();
        int k;
        int n;
        n = $urandom_range(85, 100);
        for (k = 0; k < n; k++) begin
            if ($urandom_range(0, 99) < 15) begin
                put(plain_class(), coin(), 1'b0);
            end
            put(opener(OPEN_EMB_FIRST, OPEN_ISO_LAST), coin(), 1'b0);
        end
        mixed_body(15);
        n = $urandom_range(90, 110);
        for (k = 0; k < n; k++) begin
            if ($urandom_range(0, 99) < 10) begin
                put(plain_class(), coin(), 1'b0);
            end
            put(coin() ? C_PDF : C_PDI, coin(), 1'b0);
        end
        put(C_B, coin(), coin());
    endtask

    // Drives both overflow counts well past the stack limit and drains most of them again, so
    // that the levels seen while closing show whether the counts were kept exactly.
    task automatic saturating_paragraph();
        int k;
        for (k = 0; k < SAT_OPENERS; k++) begin
            if (k % 40 == 0) begin
                put(plain_class(), coin(), 1'b0);
            end
            put(opener(OPEN_EMB_FIRST, OPEN_EMB_LAST), coin(), 1'b0);
        end
        for (k = 0; k < SAT_CLOSERS; k++) begin
            if (k % 30 == 0) begin
                put(plain_class(), coin(), 1'b0);
            end
            put(C_PDF, coin(), 1'b0);
        end
        for (k = 0; k < SAT_CLOSERS + 5; k++) begin
            if (k % 40 == 0) begin
                put(plain_class(), coin(), 1'b0);
            end
            put(opener(OPEN_ISO_FIRST, OPEN_ISO_LAST), coin(), 1'b0);
        end
        for (k = 0; k < SAT_CLOSERS; k++) begin
            if (k % 30 == 0) begin
                put(plain_class(), coin(), 1'b0);
            end
            put(C_PDI, coin(), 1'b0);
        end
        put(C_B, coin(), coin());
    endtask

    task automatic wait_all_done();
        while (char_queue.size() != 0 || i_valid || expected_levels.size() != 0) begin
            @(negedge i_clk);
        end
    endtask

    task automatic set_paragraph_level(logic lvl);
        wait_all_done();
        repeat (4) @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_wdata <= lvl;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        para_lvl = lvl;
        @(negedge i_clk);
    endtask

    initial begin : stimulus
        int seg;
        clear_paragraph();
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        put(C_PDF, 1'b0, 1'b0);
        put(C_PDI, 1'b0, 1'b0);
        put(C_L, 1'b0, 1'b0);
        put(C_R, 1'b0, 1'b0);
        put(C_RLO, 1'b0, 1'b0);
        put(C_AL, 1'b0, 1'b0);
        put(C_LRI, 1'b0, 1'b0);
        put(C_EN, 1'b0, 1'b0);
        put(C_FSI, 1'b1, 1'b0);
        put(C_ES, 1'b0, 1'b0);
        put(C_PDI, 1'b0, 1'b0);
        put(C_PDI, 1'b0, 1'b0);
        put(C_CS, 1'b0, 1'b0);
        put(C_PDF, 1'b0, 1'b0);
        put(C_LRO, 1'b0, 1'b0);
        put(C_NSM, 1'b0, 1'b0);
        put(C_BN, 1'b0, 1'b0);
        put(C_RLE, 1'b0, 1'b0);
        put(C_ET, 1'b0, 1'b0);
        put(C_RLI, 1'b0, 1'b0);
        put(C_AN, 1'b0, 1'b0);
        put(C_FSI, 1'b0, 1'b0);
        put(C_TOP_CODE, 1'b1, 1'b0);
        put(C_ON, 1'b0, 1'b1);
        put(C_S, 1'b0, 1'b0);
        put(C_WS, 1'b0, 1'b0);
        put(C_B, 1'b1, 1'b1);
        set_paragraph_level(1'b1);

        seg = 0;
        while (queued_count < RANDOM_ITEMS || seg < 10) begin
            if (seg == 1) begin
                calm <= 1'b1;
            end
            case (seg)
                1, 6: deep_paragraph();
                3: saturating_paragraph();
                default: mixed_paragraph();
            endcase
            if (seg == 1) begin
                while (char_queue.size() != 0) begin
                    @(negedge i_clk);
                end
                calm <= 1'b0;
            end
            if (seg == 2 || seg == 5 || seg == 8) begin
                set_paragraph_level(!para_lvl);
            end else begin
                while (char_queue.size() >= 8) begin
                    @(negedge i_clk);
                end
            end
            seg++;
        end

        wait_all_done();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

FILE: filelist.f
rtl/core/bxlr_pkg.sv
rtl/core/bxlr_ram.sv
rtl/core/bxlr_ctrl.sv
rtl/core/bidi_explicit_level_resolver.sv
rtl/core/bxlr_chk.sv
verif/tb_bidi_explicit_level_resolver.sv
